// File: rtl/core/voxel_ray_traversal_defines.svh
// assertion macros for the voxel ray traversal block
// used by modules that carry concurrent checks; clock aclk, reset aresetn
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VRT_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("check failed");
`define VRT_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("check failed");
`else
`define VRT_ASSERT_IMP(lbl, a, c)
`define VRT_ASSERT_NXT(lbl, a, c)
`endif
`endif

// File: rtl/core/vrt_pkg.sv
// shared types and constants of the voxel ray traversal block
// no dependencies
package vrt_pkg;
    localparam int CW = 31;
    localparam int QW = 46;
    localparam int NXT_W = 53;
    localparam int MAX_CELLS_DEF = 64;
    localparam int QDEPTH = 2;
    localparam logic [30:0] CELL_SIZE_RESET = 31'd4194304;
    localparam logic [31:0] MAX_DIST_RESET = 32'd655360000;
    localparam logic CFG_CELL_SIZE = 1'b0;
    localparam logic CFG_MAX_DIST = 1'b1;

    typedef struct packed {
        logic [15:0]   pos;
        logic          neg;
        logic          act;
        logic [QW-1:0] nxt;
        logic [QW-1:0] dlt;
    } axis_t;

    typedef struct packed {
        axis_t [2:0] ax;
    } ray_t;
endpackage

// File: rtl/core/vrt_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on vrt_pkg for default widths
module vrt_div #(
    parameter int DW = vrt_pkg::QW,
    parameter int VW = vrt_pkg::CW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quot_reg, quot_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      cand;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cand      = {rem_reg, quot_reg[DW-1]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cand >= {1'b0, divisor}) begin
                rem_next  = VW'(cand - {1'b0, divisor});
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end else begin
                rem_next  = cand[VW-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule

// File: rtl/core/vrt_front.sv
// ray setup: start cell, first crossing and step size per axis
// depends on vrt_pkg and vrt_div
module vrt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_origin_x,
    input  logic [31:0]        s_origin_y,
    input  logic [31:0]        s_origin_z,
    input  logic [15:0]        s_dir_x,
    input  logic [15:0]        s_dir_y,
    input  logic [15:0]        s_dir_z,
    input  logic [30:0]        csize,
    output logic               q_valid,
    input  logic               q_ready,
    output vrt_pkg::ray_t      q_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KDIV = 3'd1;
    localparam logic [2:0] S_NDIV = 3'd2;
    localparam logic [2:0] S_DDIV = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;
    localparam int QW = vrt_pkg::QW;
    localparam int CW = vrt_pkg::CW;

    logic [2:0]    state_reg, state_next;
    logic          go_reg, go_next;
    logic [1:0]    ax_reg, ax_next;
    logic [31:0]   o_reg [3];
    logic [15:0]   d_reg [3];
    logic [CW-1:0] c_reg;
    logic [CW-1:0] dist_reg, dist_next;
    vrt_pkg::ray_t rec_reg, rec_next;

    logic [31:0]   o_cur;
    logic [15:0]   d_cur, mag;
    logic [CW-1:0] absx, m_val;
    logic [QW-1:0] div_a;
    logic [CW-1:0] div_b;
    logic          div_done;
    logic [QW-1:0] div_q;
    logic [CW-1:0] div_r;

    vrt_div #(.DW(QW), .VW(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(go_reg),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    always_comb begin
        o_cur = o_reg[ax_reg];
        d_cur = d_reg[ax_reg];
        mag   = d_cur[15] ? 16'(~d_cur + 16'd1) : d_cur;
        absx  = o_cur[31] ? ~o_cur[30:0] : o_cur[30:0];
        m_val = o_cur[31] ? CW'(c_reg - div_r - 1'b1) : div_r;
        case (state_reg)
            S_KDIV: begin
                div_a = QW'(absx);
                div_b = c_reg;
            end
            S_NDIV: begin
                div_a = {dist_reg, 15'd0};
                div_b = CW'(mag);
            end
            default: begin
                div_a = {c_reg, 15'd0};
                div_b = CW'(mag);
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        go_next    = 1'b0;
        ax_next    = ax_reg;
        dist_next  = dist_reg;
        rec_next   = rec_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ax_next    = 2'd0;
                    state_next = S_KDIV;
                    go_next    = 1'b1;
                end
            end
            S_KDIV: begin
                if (div_done) begin
                    rec_next.ax[ax_reg].pos = o_cur[31] ? ~div_q[15:0] : div_q[15:0];
                    rec_next.ax[ax_reg].neg = d_cur[15];
                    rec_next.ax[ax_reg].act = (d_cur != 16'd0);
                    rec_next.ax[ax_reg].nxt = '0;
                    rec_next.ax[ax_reg].dlt = '0;
                    dist_next = d_cur[15] ? m_val : CW'(c_reg - m_val);
                    if (d_cur != 16'd0) begin
                        state_next = S_NDIV;
                        go_next    = 1'b1;
                    end else if (ax_reg == 2'd2) begin
                        state_next = S_PUSH;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                        go_next = 1'b1;
                    end
                end
            end
            S_NDIV: begin
                if (div_done) begin
                    rec_next.ax[ax_reg].nxt = div_q;
                    state_next = S_DDIV;
                    go_next    = 1'b1;
                end
            end
            S_DDIV: begin
                if (div_done) begin
                    rec_next.ax[ax_reg].dlt = div_q;
                    if (ax_reg == 2'd2) begin
                        state_next = S_PUSH;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_KDIV;
                        go_next    = 1'b1;
                    end
                end
            end
            S_PUSH: begin
                if (q_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
        ax_reg   <= ax_next;
        dist_reg <= dist_next;
        rec_reg  <= rec_next;
        if (state_reg == S_IDLE && s_valid) begin
            o_reg[0] <= s_origin_x;
            o_reg[1] <= s_origin_y;
            o_reg[2] <= s_origin_z;
            d_reg[0] <= s_dir_x;
            d_reg[1] <= s_dir_y;
            d_reg[2] <= s_dir_z;
            c_reg    <= csize;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign q_valid = (state_reg == S_PUSH);
    assign q_data  = rec_reg;
endmodule

// File: rtl/core/vrt_fifo.sv
// short queue of set-up rays between setup and walk
// depends on vrt_pkg
module vrt_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  vrt_pkg::ray_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output vrt_pkg::ray_t rd_data
);
    localparam int D = vrt_pkg::QDEPTH;
    localparam int PW = $clog2(D);
    localparam int NW = $clog2(D + 1);

    vrt_pkg::ray_t mem [D];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [NW-1:0] cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != NW'(D));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(D - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(D - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + NW'(push) - NW'(pop);
        end
        if (push) begin
            mem[wp_reg] <= wr_data;
        end
    end
endmodule

// File: rtl/core/vrt_walk.sv
// grid walk: one cell per cycle, while m_ready does not stall it, from a set-up ray into the output register
// depends on vrt_pkg and the assertion macro header
`include "voxel_ray_traversal_defines.svh"
module vrt_walk #(
    parameter int MAX_CELLS = vrt_pkg::MAX_CELLS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  vrt_pkg::ray_t q_data,
    input  logic [31:0]   max_dist,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_cell_x,
    output logic [15:0]   m_cell_y,
    output logic [15:0]   m_cell_z,
    output logic          m_last_cell,
    output logic          m_truncated
);
    localparam int NW = vrt_pkg::NXT_W;
    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      pos_reg [3];
    logic             neg_reg [3];
    logic             act_reg [3];
    logic [NW-1:0]    nxt_reg [3];
    logic [NW-1:0]    dlt_reg [3];
    logic             mv_reg, ml_reg, mt_reg;
    logic [15:0]      mx_reg, my_reg, mz_reg;

    logic             fire, lt01, lt02, lt12, inf, cont, last;
    logic [1:0]       a;
    logic [NW-1:0]    t_new;
    logic [CNT_W-1:0] n1;

    function automatic logic lt(input logic aa, input logic [NW-1:0] x,
                                input logic ab, input logic [NW-1:0] y);
        lt = aa && (!ab || (x < y));
    endfunction

    always_comb begin
        lt01  = lt(act_reg[0], nxt_reg[0], act_reg[1], nxt_reg[1]);
        lt02  = lt(act_reg[0], nxt_reg[0], act_reg[2], nxt_reg[2]);
        lt12  = lt(act_reg[1], nxt_reg[1], act_reg[2], nxt_reg[2]);
        a     = (lt01 && lt02) ? 2'd0 : (lt12 ? 2'd1 : 2'd2);
        t_new = nxt_reg[a];
        inf   = !act_reg[a];
        cont  = !inf && (t_new < NW'(max_dist));
        n1    = cnt_reg + 1'b1;
        last  = !cont || (n1 == CNT_W'(MAX_CELLS));
        fire  = busy_reg && (!mv_reg || m_ready);
    end

    assign q_ready = !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            if (q_valid && !busy_reg) begin
                busy_reg <= (max_dist != 32'd0);
            end else if (fire && last) begin
                busy_reg <= 1'b0;
            end
            if (fire) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
        if (q_valid && !busy_reg) begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= q_data.ax[i].pos;
                neg_reg[i] <= q_data.ax[i].neg;
                act_reg[i] <= q_data.ax[i].act;
                nxt_reg[i] <= NW'(q_data.ax[i].nxt);
                dlt_reg[i] <= NW'(q_data.ax[i].dlt);
            end
        end else if (fire) begin
            cnt_reg <= n1;
            if (!inf) begin
                pos_reg[a] <= neg_reg[a] ? pos_reg[a] - 16'd1 : pos_reg[a] + 16'd1;
                nxt_reg[a] <= nxt_reg[a] + dlt_reg[a];
            end
        end
        if (fire) begin
            mx_reg <= pos_reg[0];
            my_reg <= pos_reg[1];
            mz_reg <= pos_reg[2];
            ml_reg <= last;
            mt_reg <= cont && (n1 == CNT_W'(MAX_CELLS));
        end
    end

    assign m_valid     = mv_reg;
    assign m_cell_x    = mx_reg;
    assign m_cell_y    = my_reg;
    assign m_cell_z    = mz_reg;
    assign m_last_cell = ml_reg;
    assign m_truncated = mt_reg;

    `VRT_ASSERT_IMP(a_cnt_range, busy_reg, cnt_reg < CNT_W'(MAX_CELLS))
    `VRT_ASSERT_NXT(a_last_ends, fire && last, !busy_reg)
    `VRT_ASSERT_IMP(a_trunc_last, mv_reg && mt_reg, ml_reg)
endmodule

// File: rtl/core/voxel_ray_traversal.sv
// voxel ray traversal: setup runs its divisions on one shared bit-serial divider,
// three divisions per axis with a nonzero direction and one otherwise
// the walk then gives one cell per cycle, while m_ready does not stall it, up to MAX_CELLS
// setup of the next ray overlaps the walk of the current one through a two-entry queue
// reset: synchronous active low, clears control state, cell size 64.0, max distance 10000.0
module voxel_ray_traversal #(
    parameter int MAX_CELLS = vrt_pkg::MAX_CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_origin_x,
    input  logic [31:0] s_origin_y,
    input  logic [31:0] s_origin_z,
    input  logic [15:0] s_dir_x,
    input  logic [15:0] s_dir_y,
    input  logic [15:0] s_dir_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_cell_x,
    output logic [15:0] m_cell_y,
    output logic [15:0] m_cell_z,
    output logic        m_last_cell,
    output logic        m_truncated
);
    logic [30:0]   csize_reg, csize_eff;
    logic [31:0]   maxd_reg;
    logic          fq_valid, fq_ready, wq_valid, wq_ready;
    vrt_pkg::ray_t fq_data, wq_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csize_reg <= vrt_pkg::CELL_SIZE_RESET;
            maxd_reg  <= vrt_pkg::MAX_DIST_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                vrt_pkg::CFG_CELL_SIZE: csize_reg <= cfg_wdata[30:0];
                vrt_pkg::CFG_MAX_DIST:  maxd_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign csize_eff = (csize_reg == 31'd0) ? 31'd1 : csize_reg;

    vrt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .csize(csize_eff),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    vrt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(wq_valid), .rd_ready(wq_ready), .rd_data(wq_data)
    );

    vrt_walk #(.MAX_CELLS(MAX_CELLS)) u_walk (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(wq_valid), .q_ready(wq_ready), .q_data(wq_data),
        .max_dist(maxd_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cell_x(m_cell_x), .m_cell_y(m_cell_y), .m_cell_z(m_cell_z),
        .m_last_cell(m_last_cell), .m_truncated(m_truncated)
    );
endmodule
